### rtl/escaped_string_unescaper_unit_assert.svh
// Assertion macros for the escaped string unescaper unit.
// Depends on nothing; included by the top level ahead of its module.
`ifndef ESCAPED_STRING_UNESCAPER_UNIT_ASSERT_SVH
`define ESCAPED_STRING_UNESCAPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ESU_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define ESU_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ESU_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ESU_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### rtl/esu_pkg.sv
// Shared types, codes and decode helpers of the escaped string unescaper.
// Depends on nothing; used by escaped_string_unescaper_unit.
package esu_pkg;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_BODY  = 3'd1,
		PH_ESC   = 3'd2,
		PH_HEX   = 3'd3,
		PH_OCT   = 3'd4,
		PH_UNI   = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		REG_ESCAPE_ENABLE      = 2'd0,
		REG_QUOTED_MODE        = 2'd1,
		REG_ALLOW_SINGLE_QUOTE = 2'd2,
		REG_ALLOW_DOUBLE_QUOTE = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ESC   = 2'd1,
		ST_BAD_QUOTE = 2'd2
	} status_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;

	localparam logic [20:0] CP_MAX1 = 21'h00007F;
	localparam logic [20:0] CP_MAX2 = 21'h0007FF;
	localparam logic [20:0] CP_MAX3 = 21'h00FFFF;
	localparam logic [20:0] CP_MAX4 = 21'h10FFFF;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// {valid, byte}
	function automatic logic [8:0] simple_escape(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h5C: r = {1'b1, 8'h5C};
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			8'h6E: r = {1'b1, 8'h0A};
			8'h74: r = {1'b1, 8'h09};
			8'h72: r = {1'b1, 8'h0D};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h76: r = {1'b1, 8'h0B};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= CP_MAX1) begin
			r.b[0] = cp[7:0];
			r.n = 3'd1;
		end else if (cp <= CP_MAX2) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.n = 3'd2;
		end else if (cp <= CP_MAX3) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.n = 3'd3;
		end else if (cp <= CP_MAX4) begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

endpackage

### rtl/escaped_string_unescaper_unit.sv
// Escaped string unescaper top level: escape decoder, parse state and word serializer.
// Depends on esu_pkg and escaped_string_unescaper_unit_assert.svh.
`include "escaped_string_unescaper_unit_assert.svh"

// Decodes C-style string literal text one byte per input word. Each accepted
// word is decoded in the cycle it is taken and its results (zero to four words,
// or one empty word marking the end) land in a result register that a serializer
// hands out one word per cycle while m_tready is high. Plain text and simple
// escapes give at most one word each and run at one byte per cycle while m_tready
// is high; an item giving more words holds the input until its last word is taken
// (up to four, on a \u escape, either a five-digit one above U+FFFF or a four-digit
// one ended by an ordinary byte). An item with no result never stalls.
module escaped_string_unescaper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  esu_pkg::reg_index_t cfg_addr,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // run_last
	output logic [3:0]  m_tuser    // [0] byte_valid, [1] finished, [3:2] status
);
	import esu_pkg::*;

	logic escape_enable_q, quoted_mode_q, allow_sq_q, allow_dq_q;

	phase_t      phase_q;
	logic [20:0] digit_value_q;
	logic [2:0]  digit_count_q;
	logic [7:0]  quote_char_q;
	logic        failed_q;

	phase_t          ph_n;
	logic [20:0]     dv_n;
	logic [2:0]      dc_n;
	logic [7:0]      qc_n;
	logic            ended_n;
	status_t         st_n;
	logic [3:0][7:0] nb_n;
	logic [2:0]      cnt_n;
	logic [2:0]      words_n;

	logic [3:0][7:0] bytes_s1;
	logic [2:0]      cnt_s1;
	logic [2:0]      words_s1;
	logic            ended_s1;
	status_t         status_s1;
	logic [1:0]      beat_s1;
	logic            busy_s1;

	logic in_acc, out_acc, last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b1;
			quoted_mode_q   <= 1'b0;
			allow_sq_q      <= 1'b1;
			allow_dq_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ESCAPE_ENABLE:      escape_enable_q <= cfg_wdata;
				REG_QUOTED_MODE:        quoted_mode_q   <= cfg_wdata;
				REG_ALLOW_SINGLE_QUOTE: allow_sq_q      <= cfg_wdata;
				REG_ALLOW_DOUBLE_QUOTE: allow_dq_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       do_body;
		logic [4:0] hx;
		logic [8:0] se;
		utf8_t      u8;
		logic       is_oct;

		c       = s_tdata;
		ph_n    = phase_q;
		dv_n    = digit_value_q;
		dc_n    = digit_count_q;
		qc_n    = quote_char_q;
		ended_n = 1'b0;
		st_n    = ST_OK;
		nb_n    = '0;
		cnt_n   = '0;
		do_body = 1'b0;
		hx      = hex_decode(c);
		se      = simple_escape(c);
		u8      = '0;
		is_oct  = (c >= CH_ZERO) && (c <= CH_SEVEN);

		case (phase_q)
			PH_START: begin
				if (quoted_mode_q) begin
					if ((c == CH_SQUOTE && allow_sq_q) || (c == CH_DQUOTE && allow_dq_q)) begin
						qc_n = c;
						ph_n = PH_BODY;
					end else begin
						ended_n = 1'b1;
						st_n    = ST_BAD_QUOTE;
						ph_n    = PH_DONE;
					end
				end else begin
					qc_n    = '0;
					ph_n    = PH_BODY;
					do_body = 1'b1;
				end
			end
			PH_BODY: do_body = 1'b1;
			PH_ESC: begin
				dv_n = '0;
				dc_n = '0;
				if (se[8]) begin
					nb_n[0] = se[7:0];
					cnt_n   = 3'd1;
					ph_n    = PH_BODY;
				end else if (c == CH_X) begin
					ph_n = PH_HEX;
				end else if (c == CH_U) begin
					ph_n = PH_UNI;
				end else if (is_oct) begin
					dv_n = {18'b0, c[2:0]};
					dc_n = 3'd1;
					ph_n = PH_OCT;
				end else begin
					ended_n = 1'b1;
					st_n    = ST_BAD_ESC;
					ph_n    = PH_DONE;
				end
			end
			PH_HEX: begin
				if (!hx[4]) begin
					ended_n = 1'b1;
					st_n    = ST_BAD_ESC;
					ph_n    = PH_DONE;
				end else begin
					dv_n = {13'b0, digit_value_q[3:0], hx[3:0]};
					dc_n = digit_count_q + 3'd1;
					if (dc_n >= 3'd2) begin
						nb_n[0] = dv_n[7:0];
						cnt_n   = 3'd1;
						ph_n    = PH_BODY;
					end
				end
			end
			PH_OCT: begin
				if (is_oct) begin
					dv_n = {12'b0, digit_value_q[5:0], c[2:0]};
					dc_n = digit_count_q + 3'd1;
					if (dc_n >= 3'd3) begin
						nb_n[0] = dv_n[7:0];
						cnt_n   = 3'd1;
						ph_n    = PH_BODY;
					end
				end else begin
					nb_n[0] = digit_value_q[7:0];
					cnt_n   = 3'd1;
					ph_n    = PH_BODY;
					do_body = 1'b1;
				end
			end
			PH_UNI: begin
				if (digit_count_q < 3'd4) begin
					if (!hx[4]) begin
						ended_n = 1'b1;
						st_n    = ST_BAD_ESC;
						ph_n    = PH_DONE;
					end else begin
						dv_n = {digit_value_q[16:0], hx[3:0]};
						dc_n = digit_count_q + 3'd1;
					end
				end else if (hx[4]) begin
					dv_n  = {digit_value_q[16:0], hx[3:0]};
					u8    = utf8_encode(dv_n);
					nb_n  = u8.b;
					cnt_n = u8.n;
					ph_n  = PH_BODY;
				end else begin
					u8      = utf8_encode(digit_value_q);
					nb_n    = u8.b;
					cnt_n   = u8.n;
					ph_n    = PH_BODY;
					do_body = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_body) begin
			if (escape_enable_q && c == CH_BSLASH) begin
				ph_n = PH_ESC;
			end else if (qc_n != 8'd0 && c == qc_n) begin
				ended_n = 1'b1;
				st_n    = ST_OK;
				ph_n    = PH_DONE;
			end else begin
				nb_n[cnt_n[1:0]] = c;
				cnt_n = cnt_n + 3'd1;
			end
		end

		// end of text: flush a pending escape
		if (s_tlast && phase_q != PH_DONE && ph_n != PH_DONE) begin
			ended_n = 1'b1;
			st_n    = ST_OK;
			case (ph_n)
				PH_OCT: begin
					nb_n[0] = dv_n[7:0];
					cnt_n   = 3'd1;
				end
				PH_UNI: begin
					if (dc_n >= 3'd4) begin
						u8    = utf8_encode(dv_n);
						nb_n  = u8.b;
						cnt_n = u8.n;
					end else begin
						st_n = ST_BAD_ESC;
					end
				end
				PH_ESC, PH_HEX: st_n = ST_BAD_ESC;
				default: ;
			endcase
			ph_n = PH_DONE;
		end

		words_n = (cnt_n == 3'd0 && ended_n) ? 3'd1 : cnt_n;
	end

	assign last_beat = ({1'b0, beat_s1} == words_s1 - 3'd1);
	assign s_tready  = !busy_s1 || (m_tready && last_beat);
	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			digit_value_q <= '0;
			digit_count_q <= '0;
			quote_char_q  <= '0;
			failed_q      <= 1'b0;
		end else if (in_acc) begin
			if (s_tlast) begin
				phase_q       <= PH_START;
				digit_value_q <= '0;
				digit_count_q <= '0;
				quote_char_q  <= '0;
				failed_q      <= 1'b0;
			end else begin
				phase_q       <= ph_n;
				digit_value_q <= dv_n;
				digit_count_q <= dc_n;
				quote_char_q  <= qc_n;
				if (ended_n && st_n != ST_OK) begin
					failed_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			beat_s1 <= '0;
		end else if (in_acc && words_n != 3'd0) begin
			busy_s1 <= 1'b1;
			beat_s1 <= '0;
		end else if (out_acc && last_beat) begin
			busy_s1 <= 1'b0;
		end else if (out_acc) begin
			beat_s1 <= beat_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && words_n != 3'd0) begin
			bytes_s1  <= nb_n;
			cnt_s1    <= cnt_n;
			words_s1  <= words_n;
			ended_s1  <= ended_n;
			status_s1 <= st_n;
		end
	end

	always_comb begin
		logic vld;
		vld      = ({1'b0, beat_s1} < cnt_s1);
		m_tvalid = busy_s1;
		m_tdata  = vld ? bytes_s1[beat_s1] : 8'd0;
		m_tlast  = last_beat;
		m_tuser  = {(ended_s1 && last_beat) ? status_s1 : ST_OK,
			ended_s1 && last_beat, vld};
	end

	`ESU_ASSERT_IMPLY(a_failed_done, clk, arst_n, failed_q, phase_q == PH_DONE)
	`ESU_ASSERT_IMPLY(a_beat_range, clk, arst_n, busy_s1,
		words_s1 != 3'd0 && {1'b0, beat_s1} < words_s1)
	`ESU_ASSERT_NEXT(a_last_rearms, clk, arst_n, in_acc && s_tlast,
		phase_q == PH_START && !failed_q)
	`ESU_ASSERT_IMPLY(a_end_status, clk, arst_n, m_tvalid && !(ended_s1 && last_beat),
		m_tuser[3:2] == ST_OK)

endmodule
